[rtl/htfl_pkg.sv]
package htfl_pkg;

    localparam int CAPACITY    = 256;
    localparam int SLOT_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LINK_W      = SLOT_W + 1;
    localparam int HANDLE_W    = 8;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int S_TDATA_W   = 104;
    localparam int M_TDATA_W   = 176;

    localparam logic [LINK_W-1:0] NO_SLOT = LINK_W'(CAPACITY);

    localparam logic [2:0] OP_OPEN    = 3'd0;
    localparam logic [2:0] OP_CLOSE   = 3'd1;
    localparam logic [2:0] OP_LOOKUP  = 3'd2;
    localparam logic [2:0] OP_ADD_RD  = 3'd3;
    localparam logic [2:0] OP_ADD_WR  = 3'd4;
    localparam logic [2:0] OP_BAD     = 3'd5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    localparam logic [1:0] KIND_UNUSED = 2'd0;
    localparam logic [1:0] KIND_DIR    = 2'd1;
    localparam logic [1:0] KIND_FILE   = 2'd2;

    typedef struct packed {
        logic [2:0]          op;
        logic                open_file;
        logic [31:0]         flags;
        logic                h_over;
        logic [SLOT_W-1:0]   slot;
        logic [HANDLE_W-1:0] echo;
        logic [31:0]         count;
    } req_t;

    typedef struct packed {
        logic [63:0]         write_total;
        logic [63:0]         read_total;
        logic [31:0]         flags;
        logic [1:0]          kind;
        logic [HANDLE_W-1:0] handle;
        logic [1:0]          status;
    } res_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [31:0]       flags;
        logic [63:0]       read_total;
        logic [63:0]       write_total;
        logic [LINK_W-1:0] next_free;
    } ent_t;

    function automatic logic [HANDLE_W-1:0] to_handle(input logic [SLOT_W-1:0] slot);
        logic [HANDLE_W+SLOT_W-1:0] wide;
        wide = {{HANDLE_W{1'b0}}, slot};
        return wide[HANDLE_W-1:0];
    endfunction

endpackage

[rtl/htfl_ram.sv]
module htfl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                                       aclk,
    input  logic                                       we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                           wdata,
    input  logic                                       re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

[rtl/htfl_front.sv]
module htfl_front (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [htfl_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                             q_valid,
    input  logic                             q_ready,
    output htfl_pkg::req_t                   q_req
);
    import htfl_pkg::*;

    req_t              in_req;
    req_t              mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QPTR_W:0]   count_reg, count_next;
    logic              push, pop;

    always_comb begin
        in_req.flags     = s_tdata[35:4];
        in_req.open_file = s_tdata[3];
        in_req.count     = s_tdata[99:68];
        in_req.slot      = s_tdata[36 +: SLOT_W];
        in_req.echo      = s_tdata[43:36];
        in_req.h_over    = s_tdata[67:36] >= 32'(CAPACITY);
        unique case (s_tdata[2:0])
            OP_OPEN:   in_req.op = OP_OPEN;
            OP_CLOSE:  in_req.op = OP_CLOSE;
            OP_LOOKUP: in_req.op = OP_LOOKUP;
            OP_ADD_RD: in_req.op = OP_ADD_RD;
            OP_ADD_WR: in_req.op = OP_ADD_WR;
            default:   in_req.op = OP_BAD;
        endcase
    end

    assign s_tready = count_reg != (QPTR_W + 1)'(QUEUE_DEPTH);
    assign q_valid  = count_reg != '0;
    assign q_req    = mem_reg[rd_ptr_reg];
    assign push     = s_tvalid && s_tready;
    assign pop      = q_valid && q_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_req;
        end
    end

endmodule

[rtl/htfl_back.sv]
module htfl_back (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           q_valid,
    output logic           q_ready,
    input  htfl_pkg::req_t q_req,
    output logic           m_valid,
    input  logic           m_ready,
    output htfl_pkg::res_t m_res
);
    import htfl_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic              state_reg, state_next;
    req_t              cur_reg, cur_next;
    logic [LINK_W-1:0] free_head_reg, free_head_next;
    logic [LINK_W-1:0] grown_reg, grown_next;
    logic              out_valid_reg, out_valid_next;
    res_t              out_reg, out_next;

    logic              ram_we, ram_re;
    logic [SLOT_W-1:0] ram_waddr, ram_raddr;
    ent_t              ram_wdata, ram_rdata, upd;
    logic              out_free, head_empty, range_bad, in_use;
    logic [SLOT_W-1:0] head_slot;

    htfl_ram #(
        .WIDTH ($bits(ent_t)),
        .DEPTH (CAPACITY)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign out_free   = !out_valid_reg || m_ready;
    assign head_empty = free_head_reg == NO_SLOT;
    assign head_slot  = free_head_reg[SLOT_W-1:0];
    assign range_bad  = q_req.h_over || ({1'b0, q_req.slot} >= grown_reg);
    assign in_use     = (ram_rdata.kind == KIND_DIR) || (ram_rdata.kind == KIND_FILE);
    assign m_valid    = out_valid_reg;
    assign m_res      = out_reg;

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        free_head_next = free_head_reg;
        grown_next     = grown_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        q_ready        = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = cur_reg.slot;
        ram_wdata      = ram_rdata;
        ram_re         = 1'b0;
        ram_raddr      = q_req.slot;
        upd            = ram_rdata;

        unique case (state_reg)
            S_IDLE: begin
                if (q_valid) begin
                    if (q_req.op == OP_OPEN) begin
                        if (!head_empty) begin
                            q_ready    = 1'b1;
                            ram_re     = 1'b1;
                            ram_raddr  = head_slot;
                            cur_next   = q_req;
                            state_next = S_EXEC;
                        end else if (out_free) begin
                            q_ready        = 1'b1;
                            out_valid_next = 1'b1;
                            out_next       = '0;
                            if (grown_reg == NO_SLOT) begin
                                out_next.status = ST_FULL;
                            end else begin
                                ram_we                = 1'b1;
                                ram_waddr             = grown_reg[SLOT_W-1:0];
                                ram_wdata             = '0;
                                ram_wdata.kind        = q_req.open_file ? KIND_FILE : KIND_DIR;
                                ram_wdata.flags       = q_req.flags;
                                ram_wdata.next_free   = NO_SLOT;
                                grown_next            = grown_reg + LINK_W'(1);
                                out_next.status       = ST_OK;
                                out_next.handle       = to_handle(grown_reg[SLOT_W-1:0]);
                                out_next.kind         = ram_wdata.kind;
                                out_next.flags        = q_req.open_file ? q_req.flags : '0;
                            end
                        end
                    end else if (q_req.op == OP_BAD) begin
                        if (out_free) begin
                            q_ready         = 1'b1;
                            out_valid_next  = 1'b1;
                            out_next        = '0;
                            out_next.status = ST_BAD;
                        end
                    end else if (range_bad) begin
                        if (out_free) begin
                            q_ready         = 1'b1;
                            out_valid_next  = 1'b1;
                            out_next        = '0;
                            out_next.status = ST_BAD;
                            out_next.handle = q_req.echo;
                        end
                    end else begin
                        q_ready    = 1'b1;
                        ram_re     = 1'b1;
                        cur_next   = q_req;
                        state_next = S_EXEC;
                    end
                end
            end
            S_EXEC: begin
                if (out_free) begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.handle = cur_reg.echo;
                    if (cur_reg.op == OP_OPEN) begin
                        ram_we              = 1'b1;
                        ram_waddr           = head_slot;
                        ram_wdata           = '0;
                        ram_wdata.kind      = cur_reg.open_file ? KIND_FILE : KIND_DIR;
                        ram_wdata.flags     = cur_reg.flags;
                        ram_wdata.next_free = ram_rdata.next_free;
                        free_head_next      = ram_rdata.next_free;
                        out_next.status     = ST_OK;
                        out_next.handle     = to_handle(head_slot);
                        out_next.kind       = ram_wdata.kind;
                        out_next.flags      = cur_reg.open_file ? cur_reg.flags : '0;
                    end else if (!in_use) begin
                        out_next.status = ST_BAD;
                    end else if (cur_reg.op == OP_CLOSE) begin
                        ram_we              = 1'b1;
                        ram_wdata.kind      = KIND_UNUSED;
                        ram_wdata.next_free = free_head_reg;
                        free_head_next      = {1'b0, cur_reg.slot};
                        out_next.status     = ST_OK;
                    end else begin
                        if ((ram_rdata.kind == KIND_FILE) && (cur_reg.count != '0)) begin
                            if (cur_reg.op == OP_ADD_RD) begin
                                upd.read_total = ram_rdata.read_total + 64'(cur_reg.count);
                            end else if (cur_reg.op == OP_ADD_WR) begin
                                upd.write_total = ram_rdata.write_total + 64'(cur_reg.count);
                            end
                        end
                        ram_we          = cur_reg.op != OP_LOOKUP;
                        ram_wdata       = upd;
                        out_next.status = ST_OK;
                        out_next.kind   = upd.kind;
                        if (upd.kind == KIND_FILE) begin
                            out_next.flags       = upd.flags;
                            out_next.read_total  = upd.read_total;
                            out_next.write_total = upd.write_total;
                        end
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            free_head_reg <= NO_SLOT;
            grown_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            free_head_reg <= free_head_next;
            grown_reg     <= grown_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

    // The free list only ever links slots that have already been grown.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (free_head_reg != NO_SLOT) |-> (free_head_reg < grown_reg))
        else $error("free list head beyond grown slots");

    // The table grows by at most one slot per transaction and never shrinks.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (grown_reg != $past(grown_reg)) |-> (grown_reg == $past(grown_reg) + LINK_W'(1)))
        else $error("grown slot count moved by more than one");

    // An open that needs a table read is only started with a slot on the free list.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_EXEC && cur_reg.op == OP_OPEN) |-> !head_empty)
        else $error("open pop with an empty free list");

endmodule

[rtl/handle_table_free_list.sv]
// Channel  Direction  Ports                               Contents
// s_       in         s_tvalid s_tready s_tdata[103:0]    one request transaction
// m_       out        m_tvalid m_tready m_tdata[175:0]    one response transaction
//
// A request that reads the table (close, lookup, the adds, and an open that
// pops the free list) first issues the registered table read, then updates
// the entry and forms the response once the output register is free.
// An open that grows the table, a full table, an out-of-range handle and an
// unknown operation are answered without a table read. Reset is synchronous on
// aresetn and needs no clearing pass. A two-deep request queue holds up to two
// requests while the back end is busy or a response is held by a low m_tready,
// and s_tready falls while both places are taken.
module handle_table_free_list (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // operation[2:0], open_kind[3], open_flags[35:4], handle_in[67:36],
    // byte_count[99:68], zero pad [103:100]
    input  logic [htfl_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // status[1:0], handle_out[9:2], kind_out[11:10], flags_out[43:12],
    // read_total_out[107:44], write_total_out[171:108], zero pad [175:172]
    output logic [htfl_pkg::M_TDATA_W-1:0] m_tdata
);
    import htfl_pkg::*;

    logic q_valid, q_ready;
    req_t q_req;
    res_t res;

    htfl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_valid  (q_valid),
        .q_ready  (q_ready),
        .q_req    (q_req)
    );

    htfl_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_ready (q_ready),
        .q_req   (q_req),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    assign m_tdata = {4'b0000, res.write_total, res.read_total, res.flags,
                      res.kind, res.handle, res.status};

endmodule

[tb/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import htfl_pkg::*;

    localparam logic [2:0] OP_RSVD_6    = 3'd6;
    localparam logic [2:0] OP_RSVD_7    = 3'd7;
    localparam int         RANDOM_ITEMS = 1800;
    localparam int         EPOCH_LEN    = 450;
    localparam int         DIRECTED_LEN = 26;
    localparam int         DRAIN_CYCLES = 16;
    localparam int         CYCLE_LIMIT  = 400000;
    localparam int         PRINT_LIMIT  = 50;

    typedef struct packed {
        logic [2:0]  op;
        logic        kind;
        logic [31:0] flags;
        logic [31:0] handle;
        logic [31:0] count;
    } req_item_t;

    typedef struct packed {
        req_item_t req;
        logic      quoted;
        res_t      want;
    } plan_row_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow of the handle table, advanced once per accepted request.
    logic [1:0]        slot_kind     [CAPACITY];
    logic [31:0]       slot_flags    [CAPACITY];
    logic [63:0]       slot_rd_bytes [CAPACITY];
    logic [63:0]       slot_wr_bytes [CAPACITY];
    logic [LINK_W-1:0] slot_next     [CAPACITY];
    logic [LINK_W-1:0] free_top    = NO_SLOT;
    int                grown_count = 0;
    int                live_count  = 0;
    int                peak_live   = 0;

    res_t      pending_responses[$];
    plan_row_t directed_plan [DIRECTED_LEN];

    int burst_left     = 0;
    int mismatches     = 0;
    int responses_seen = 0;
    int cycle_count    = 0;
    int requests_sent  = 0;
    int opens_ok       = 0;
    int opens_full     = 0;
    int closes_ok      = 0;
    int file_updates   = 0;
    int rejected       = 0;

    logic [1:0]  ready_mode    = 2'd0;
    int          ready_left    = 0;
    logic [15:0] ready_pattern = 16'h1;

    handle_table_free_list i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic req_item_t request_of(logic [2:0] op, logic kind, logic [31:0] flags,
                                             logic [31:0] handle, logic [31:0] count);
        req_item_t r;
        r.op     = op;
        r.kind   = kind;
        r.flags  = flags;
        r.handle = handle;
        r.count  = count;
        return r;
    endfunction

    function automatic res_t quoted_result(logic [1:0] status, logic [7:0] handle,
                                           logic [1:0] kind, logic [31:0] flags);
        res_t o;
        o        = '0;
        o.status = status;
        o.handle = handle;
        o.kind   = kind;
        o.flags  = flags;
        return o;
    endfunction

    function automatic res_t apply_request(req_item_t r);
        res_t o;
        int   s;
        o = '0;
        if (r.op == OP_OPEN) begin
            if (free_top == NO_SLOT) begin
                if (grown_count >= CAPACITY) begin
                    o.status = ST_FULL;
                    opens_full++;
                    return o;
                end
                s = grown_count;
                grown_count++;
                slot_next[s] = free_top;
                free_top     = LINK_W'(s);
            end
            s                = int'(free_top);
            free_top         = slot_next[s];
            slot_kind[s]     = r.kind ? KIND_FILE : KIND_DIR;
            slot_flags[s]    = r.flags;
            slot_rd_bytes[s] = '0;
            slot_wr_bytes[s] = '0;
            live_count++;
            if (live_count > peak_live) begin
                peak_live = live_count;
            end
            opens_ok++;
            o.handle = HANDLE_W'(s);
        end else if (r.op > OP_ADD_WR) begin
            o.status = ST_BAD;
            rejected++;
            return o;
        end else begin
            o.handle = r.handle[HANDLE_W-1:0];
            if (r.handle >= 32'(grown_count) ||
                slot_kind[r.handle[SLOT_W-1:0]] == KIND_UNUSED) begin
                o.status = ST_BAD;
                rejected++;
                return o;
            end
            s = int'(r.handle);
            if (r.op == OP_CLOSE) begin
                slot_kind[s] = KIND_UNUSED;
                slot_next[s] = free_top;
                free_top     = LINK_W'(s);
                live_count--;
                closes_ok++;
                return o;
            end
            if (slot_kind[s] == KIND_FILE && r.count != '0) begin
                if (r.op == OP_ADD_RD) begin
                    slot_rd_bytes[s] = slot_rd_bytes[s] + 64'(r.count);
                end else if (r.op == OP_ADD_WR) begin
                    slot_wr_bytes[s] = slot_wr_bytes[s] + 64'(r.count);
                end
                file_updates++;
            end
        end
        o.kind = slot_kind[s];
        if (slot_kind[s] == KIND_FILE) begin
            o.flags       = slot_flags[s];
            o.read_total  = slot_rd_bytes[s];
            o.write_total = slot_wr_bytes[s];
        end
        return o;
    endfunction

    // Mostly live slots, then wide values, handles below the capacity and grown slots.
    function automatic logic [31:0] pick_handle();
        int pick;
        int tries;
        int slot;
        pick = $urandom_range(0, 99);
        if (pick < 75 && live_count > 0) begin
            for (tries = 0; tries < 16; tries++) begin
                slot = $urandom_range(0, grown_count - 1);
                if (slot_kind[slot] != KIND_UNUSED) begin
                    return 32'(slot);
                end
            end
            for (slot = 0; slot < grown_count; slot++) begin
                if (slot_kind[slot] != KIND_UNUSED) begin
                    return 32'(slot);
                end
            end
        end
        if (pick < 80) begin
            return $urandom;
        end
        if (pick < 86) begin
            return 32'($urandom_range(0, CAPACITY - 1));
        end
        if (pick < 93) begin
            return {24'($urandom_range(1, 24'hFF_FFFF)), 8'($urandom)};
        end
        if (grown_count > 0) begin
            return 32'($urandom_range(0, grown_count - 1));
        end
        return 32'hFFFF_FFFF;
    endfunction

    // Even epochs fill the table past full, odd epochs drain it again.
    function automatic req_item_t random_request(int idx);
        req_item_t r;
        int        pick;
        int        open_pct;
        int        close_pct;
        r.kind    = 1'($urandom);
        r.flags   = $urandom;
        r.count   = $urandom;
        open_pct  = ((idx / EPOCH_LEN) % 2 == 0) ? 70 : 10;
        close_pct = ((idx / EPOCH_LEN) % 2 == 0) ? 8 : 50;
        pick      = $urandom_range(0, 99);
        if (pick < open_pct) begin
            r.op = OP_OPEN;
        end else if (pick < open_pct + close_pct) begin
            r.op = OP_CLOSE;
        end else if (pick < open_pct + close_pct + 3) begin
            r.op = 3'($urandom_range(OP_BAD, OP_RSVD_7));
        end else begin
            case ($urandom_range(0, 2))
                0: begin
                    r.op = OP_LOOKUP;
                end
                1: begin
                    r.op = OP_ADD_RD;
                end
                default: begin
                    r.op = OP_ADD_WR;
                end
            endcase
        end
        pick = $urandom_range(0, 9);
        if (pick == 0) begin
            r.count = '0;
        end else if (pick == 1) begin
            r.count = '1;
        end
        r.handle = pick_handle();
        return r;
    endfunction

    task automatic send_request(req_item_t r, logic quoted, res_t want);
        res_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0, r.count, r.handle, r.flags, r.kind, r.op};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        predicted = apply_request(r);
        pending_responses.push_back(quoted ? want : predicted);
        requests_sent++;
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 150)
                                                     : $urandom_range(1, 12);
        end else begin
            burst_left--;
        end
    endtask

    task automatic report_mismatch(string field, logic [63:0] got, logic [63:0] want);
        mismatches++;
        if (mismatches <= PRINT_LIMIT) begin
            $display("Mismatch on response %0d, %s: got %0h, expected %0h.",
                     responses_seen, field, got, want);
        end
    endtask

    always @(posedge aclk) begin
        if (ready_left == 0) begin
            ready_mode    <= 2'($urandom_range(0, 2));
            ready_left    <= $urandom_range(32, 300);
            ready_pattern <= 16'($urandom) | 16'h1;
        end else begin
            ready_left <= ready_left - 1;
            if (ready_mode == 2'd2) begin
                ready_pattern <= {ready_pattern[0], ready_pattern[15:1]};
            end
        end
        case (ready_mode)
            2'd0: begin
                m_tready <= 1'b1;
            end
            2'd1: begin
                m_tready <= ($urandom_range(0, 9) < 6);
            end
            default: begin
                m_tready <= ready_pattern[0];
            end
        endcase
    end

    always @(posedge aclk) begin
        res_t got;
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            responses_seen++;
            got = res_t'(m_tdata[$bits(res_t)-1:0]);
            if (pending_responses.size() == 0) begin
                report_mismatch("unexpected transaction", 64'(got.handle), '0);
            end else begin
                want = pending_responses.pop_front();
                if (got.status !== want.status) begin
                    report_mismatch("status", 64'(got.status), 64'(want.status));
                end
                if (got.handle !== want.handle) begin
                    report_mismatch("handle_out", 64'(got.handle), 64'(want.handle));
                end
                if (got.kind !== want.kind) begin
                    report_mismatch("kind_out", 64'(got.kind), 64'(want.kind));
                end
                if (got.flags !== want.flags) begin
                    report_mismatch("flags_out", 64'(got.flags), 64'(want.flags));
                end
                if (got.read_total !== want.read_total) begin
                    report_mismatch("read_total_out", got.read_total, want.read_total);
                end
                if (got.write_total !== want.write_total) begin
                    report_mismatch("write_total_out", got.write_total, want.write_total);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles with %0d responses outstanding.",
                     cycle_count, pending_responses.size());
            $display("handle_table_free_list verification failed");
            $finish;
        end
    end

    initial begin
        int i;
        directed_plan = '{
            '{request_of(OP_LOOKUP, 1'b0, '0, 32'hFFFF_FFFF, '0), 1'b1,
              quoted_result(ST_BAD, 8'hFF, KIND_UNUSED, '0)},
            '{request_of(OP_CLOSE, 1'b0, '0, 32'(CAPACITY), '0), 1'b1,
              quoted_result(ST_BAD, 8'h00, KIND_UNUSED, '0)},
            '{request_of(OP_BAD, 1'b1, '1, '1, '1), 1'b1,
              quoted_result(ST_BAD, 8'h00, KIND_UNUSED, '0)},
            '{request_of(OP_RSVD_6, 1'b0, 32'h1234_5678, 32'h0000_0001, 32'h9), 1'b1,
              quoted_result(ST_BAD, 8'h00, KIND_UNUSED, '0)},
            '{request_of(OP_RSVD_7, 1'b1, '1, 32'h0000_0002, '1), 1'b1,
              quoted_result(ST_BAD, 8'h00, KIND_UNUSED, '0)},
            '{request_of(OP_OPEN, 1'b0, '1, '1, '1), 1'b1,
              quoted_result(ST_OK, 8'h00, KIND_DIR, '0)},
            '{request_of(OP_OPEN, 1'b1, '1, '0, '0), 1'b1,
              quoted_result(ST_OK, 8'h01, KIND_FILE, '1)},
            '{request_of(OP_OPEN, 1'b1, '0, '0, '0), 1'b1,
              quoted_result(ST_OK, 8'h02, KIND_FILE, '0)},
            '{request_of(OP_ADD_RD, 1'b0, '0, 32'h1, '1), 1'b0, '0},
            '{request_of(OP_ADD_RD, 1'b1, '1, 32'h1, '1), 1'b0, '0},
            '{request_of(OP_ADD_WR, 1'b0, '0, 32'h1, '0), 1'b0, '0},
            '{request_of(OP_ADD_WR, 1'b0, '0, 32'h1, 32'h1), 1'b0, '0},
            '{request_of(OP_ADD_RD, 1'b0, '0, 32'h0, 32'h5), 1'b0, '0},
            '{request_of(OP_ADD_WR, 1'b0, '0, 32'h0, '1), 1'b0, '0},
            '{request_of(OP_LOOKUP, 1'b0, '0, 32'h1, '0), 1'b0, '0},
            '{request_of(OP_LOOKUP, 1'b1, '1, 32'h0, '1), 1'b0, '0},
            '{request_of(OP_CLOSE, 1'b0, '0, 32'h1, '0), 1'b1,
              quoted_result(ST_OK, 8'h01, KIND_UNUSED, '0)},
            '{request_of(OP_CLOSE, 1'b0, '0, 32'h1, '0), 1'b1,
              quoted_result(ST_BAD, 8'h01, KIND_UNUSED, '0)},
            '{request_of(OP_LOOKUP, 1'b0, '0, 32'h1, '0), 1'b1,
              quoted_result(ST_BAD, 8'h01, KIND_UNUSED, '0)},
            '{request_of(OP_CLOSE, 1'b0, '0, 32'h0, '0), 1'b1,
              quoted_result(ST_OK, 8'h00, KIND_UNUSED, '0)},
            '{request_of(OP_OPEN, 1'b1, 32'hA5A5_A5A5, '0, '0), 1'b0, '0},
            '{request_of(OP_OPEN, 1'b0, 32'h5A5A_5A5A, '0, '0), 1'b0, '0},
            '{request_of(OP_OPEN, 1'b1, 32'hFFFF_0000, '0, '0), 1'b0, '0},
            '{request_of(OP_ADD_WR, 1'b0, '0, 32'h0000_0103, 32'h7), 1'b1,
              quoted_result(ST_BAD, 8'h03, KIND_UNUSED, '0)},
            '{request_of(OP_ADD_RD, 1'b0, '0, 32'h8000_0002, 32'h7), 1'b1,
              quoted_result(ST_BAD, 8'h02, KIND_UNUSED, '0)},
            '{request_of(OP_LOOKUP, 1'b0, '0, 32'h2, '0), 1'b0, '0}
        };

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        for (i = 0; i < DIRECTED_LEN; i++) begin
            send_request(directed_plan[i].req, directed_plan[i].quoted, directed_plan[i].want);
        end
        for (i = 0; i < RANDOM_ITEMS; i++) begin
            send_request(random_request(i), 1'b0, '0);
        end
        s_tvalid <= 1'b0;

        while (pending_responses.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests: %0d opens granted, %0d refused as full, %0d closes.",
                 requests_sent, opens_ok, opens_full, closes_ok);
        $display("File byte updates %0d, rejected requests %0d, peak occupancy %0d of %0d.",
                 file_updates, rejected, peak_live, CAPACITY);
        if (mismatches == 0) begin
            $display("handle_table_free_list verification clean");
        end else begin
            $display("handle_table_free_list verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/htfl_pkg.sv
rtl/htfl_ram.sv
rtl/htfl_front.sv
rtl/htfl_back.sv
rtl/handle_table_free_list.sv
tb/tb_top.sv
